@@ sv/fc_pkg.sv @@
// shared types, widths and helpers for the frustum sphere culler
// no dependencies; every other file refers to this package by scoped names
package fc_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int TAG_W = 16;
    localparam int IDX_W = 4;
    localparam int RAD_W = WORD_W - 1;
    localparam int RAW_W = WORD_W + 1;
    localparam int SQ_W = 2 * RAW_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int LEN_W = SUM_W / 2;
    localparam int SREM_W = LEN_W + 3;
    localparam int NUM_W = RAW_W + FRAC_W;
    localparam int DREM_W = LEN_W + 1;
    localparam int PROD_W = 2 * WORD_W;
    localparam int ACC_W = PROD_W + 4;
    localparam int NPLANES = 6;
    localparam int PLANE_W = 3;
    localparam int CNT_W = 6;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_TEST    = 2'd2,
        OP_NONE    = 2'd3
    } fc_op_t;

    typedef struct packed {
        fc_op_t                   op;
        logic [IDX_W-1:0]         idx;
        logic signed [WORD_W-1:0] value;
        logic signed [WORD_W-1:0] cx;
        logic signed [WORD_W-1:0] cy;
        logic signed [WORD_W-1:0] cz;
        logic [RAD_W-1:0]         radius;
        logic [TAG_W-1:0]         tag;
    } fc_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fc_qstat_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_RD_ADDR,
        B_RD_DATA,
        B_SQ_MUL,
        B_SQ_ACC,
        B_SQRT,
        B_DIV_INIT,
        B_DIV,
        B_WR,
        B_TEST,
        B_OUT
    } fc_bstate_t;

    // clamp a sign and magnitude to a signed word
    function automatic logic [WORD_W-1:0] sat_word(input logic neg, input logic [NUM_W-1:0] m);
        logic [NUM_W-1:0] lim;
        logic [WORD_W-1:0] v;
        lim = neg ? (NUM_W'(1) << (WORD_W - 1)) : ((NUM_W'(1) << (WORD_W - 1)) - NUM_W'(1));
        v = (m > lim) ? lim[WORD_W-1:0] : m[WORD_W-1:0];
        return neg ? (~v + WORD_W'(1)) : v;
    endfunction

endpackage

@@ sv/fc_ifs.sv @@
// valid/ready channel interfaces for sphere culler commands and results
// depends on fc_pkg for field widths
interface fc_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       opcode;
    logic [fc_pkg::IDX_W-1:0]         elem_index;
    logic signed [fc_pkg::WORD_W-1:0] elem_value;
    logic signed [fc_pkg::WORD_W-1:0] center_x;
    logic signed [fc_pkg::WORD_W-1:0] center_y;
    logic signed [fc_pkg::WORD_W-1:0] center_z;
    logic [fc_pkg::RAD_W-1:0]         sphere_radius;
    logic [fc_pkg::TAG_W-1:0]         sphere_tag;

    modport source (
        output valid, opcode, elem_index, elem_value, center_x, center_y, center_z,
               sphere_radius, sphere_tag,
        input  ready
    );
    modport sink (
        input  valid, opcode, elem_index, elem_value, center_x, center_y, center_z,
               sphere_radius, sphere_tag,
        output ready
    );
endinterface

interface fc_rslt_if;
    logic                     valid;
    logic                     ready;
    logic [fc_pkg::TAG_W-1:0] result_tag;
    logic                     visible;

    modport source (output valid, result_tag, visible, input ready);
    modport sink (input valid, result_tag, visible, output ready);
endinterface

@@ sv/frustum_sphere_cull.sv @@
// sphere test: plane read, multiply and sum overlap, one plane per cycle, then the result register is loaded
// matrix load: written from the idle state; plane extraction: runs on the bit-serial
// square root (34 steps) and divider (49 steps per component) shared by all planes
// commands queue up to 4 deep while the engine works; results wait in an output register
// asynchronous active-low reset clears control state and the store valid bits, so
// matrix and planes read as zero until written
module frustum_sphere_cull (
    input logic       clk,
    input logic       rst_n,
    fc_cmd_if.sink    cmd,
    fc_rslt_if.source rslt
);

    fc_pkg::fc_qstat_t q_stat;
    fc_pkg::fc_cmd_t   q_entry;
    fc_pkg::fc_cmd_t   q_head;
    logic              q_push;
    logic              q_pop;

    fc_front u_front (
        .cmd     (cmd),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    fc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_entry),
        .pop   (q_pop),
        .dout  (q_head),
        .stat  (q_stat)
    );

    fc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_stat.empty),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .rslt      (rslt)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    a_drop_unused: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.opcode == fc_pkg::OP_NONE) |-> !q_push)
        else $error("unused opcode entered the queue");
`endif

endmodule

@@ sv/fc_front.sv @@
// front end: accepts command beats, drops unused opcodes, packs queue entries
// depends on fc_pkg and fc_ifs
module fc_front (
    fc_cmd_if.sink             cmd,
    input  fc_pkg::fc_qstat_t  q_stat,
    output logic               q_push,
    output fc_pkg::fc_cmd_t    q_entry
);

    always_comb
    begin
        cmd.ready = !q_stat.full;
        q_entry.op = fc_pkg::fc_op_t'(cmd.opcode);
        q_entry.idx = cmd.elem_index;
        q_entry.value = cmd.elem_value;
        q_entry.cx = cmd.center_x;
        q_entry.cy = cmd.center_y;
        q_entry.cz = cmd.center_z;
        q_entry.radius = cmd.sphere_radius;
        q_entry.tag = cmd.sphere_tag;
        // an unused opcode is taken and forgotten
        q_push = cmd.valid && !q_stat.full && (q_entry.op != fc_pkg::OP_NONE);
    end

endmodule

@@ sv/fc_queue.sv @@
// short command queue between the front end and the execution engine
// depends on fc_pkg
module fc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fc_pkg::fc_cmd_t   din,
    input  logic              pop,
    output fc_pkg::fc_cmd_t   dout,
    output fc_pkg::fc_qstat_t stat
);

    fc_pkg::fc_cmd_t              slot_reg [fc_pkg::QDEPTH];
    logic [fc_pkg::QPTR_W-1:0]    wptr_reg, wptr_next;
    logic [fc_pkg::QPTR_W-1:0]    rptr_reg, rptr_next;
    logic [fc_pkg::QPTR_W:0]      cnt_reg, cnt_next;

    always_comb
    begin
        wptr_next = wptr_reg + (push ? fc_pkg::QPTR_W'(1) : '0);
        rptr_next = rptr_reg + (pop ? fc_pkg::QPTR_W'(1) : '0);
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        stat.full = (cnt_reg == (fc_pkg::QPTR_W+1)'(fc_pkg::QDEPTH));
        stat.empty = (cnt_reg == '0);
        dout = slot_reg[rptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= din;
        end
    end

endmodule

@@ sv/fc_back.sv @@
// execution engine: matrix loads, plane extraction (sqrt and divide), sphere tests
// depends on fc_pkg and fc_ifs; holds the matrix and plane memories
module fc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  fc_pkg::fc_cmd_t cmd,
    output logic            cmd_pop,
    fc_rslt_if.source       rslt
);

    localparam int W = fc_pkg::WORD_W;

    fc_pkg::fc_bstate_t state_reg, state_next;

    // matrix: 4 rows of 4 words, row k holds m[4k..4k+3]
    logic [3:0][W-1:0] mtx_mem [4];
    logic [15:0]       mtx_vld_reg;
    logic [3:0][W-1:0] mtx_rd_reg;
    logic [3:0]        mtx_vrd_reg;
    logic              mtx_we;

    // planes: one row of four components per plane
    logic [3:0][W-1:0] pln_mem [fc_pkg::NPLANES];
    logic [fc_pkg::NPLANES-1:0] pln_vld_reg;
    logic [3:0][W-1:0] pln_rd_reg;
    logic              pln_vrd_reg;
    logic              pln_we;
    logic              pln_re;

    logic [fc_pkg::PLANE_W-1:0] plane_reg, plane_next;
    logic [1:0]                 kcnt_reg, kcnt_next;
    logic signed [fc_pkg::RAW_W-1:0] raw_reg [4];
    logic signed [fc_pkg::RAW_W-1:0] raw_new;
    logic                       raw_we;
    logic [fc_pkg::SQ_W-1:0]    sq_reg, sq_next;
    logic [fc_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [fc_pkg::SREM_W-1:0]  rem_reg, rem_next;
    logic [fc_pkg::LEN_W-1:0]   root_reg, root_next;
    logic [fc_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [fc_pkg::DREM_W-2:0]  drem_reg, drem_next;
    logic [fc_pkg::NUM_W-1:0]   num_reg, num_next;
    logic [W-1:0]               comp_reg [4];
    logic [W-1:0]               comp_new;
    logic                       comp_we;

    logic signed [W-1:0]        cx_reg, cy_reg, cz_reg;
    logic [fc_pkg::RAD_W-1:0]   rad_reg;
    logic [fc_pkg::TAG_W-1:0]   tag_reg;
    logic                       ld_sphere;

    logic [fc_pkg::PLANE_W-1:0] iss_reg, iss_next;
    logic                       rdv_reg, rdv_next, rdl_reg, rdl_next;
    logic                       mulv_reg, mulv_next, mull_reg, mull_next;
    logic signed [fc_pkg::PROD_W-1:0] prod_reg [3];
    logic signed [fc_pkg::PROD_W-1:0] prod_next [3];
    logic [W-1:0]               p3_reg, p3_next;
    logic                       vis_reg, vis_next;

    logic                       out_valid_reg, out_valid_next;
    logic [fc_pkg::TAG_W-1:0]   out_tag_reg, out_tag_next;
    logic                       out_vis_reg, out_vis_next;

    always_comb
    begin
        logic [W-1:0] wa, wb;
        logic [fc_pkg::RAW_W-1:0] rmag;
        logic [fc_pkg::SREM_W-1:0] srem, strial;
        logic [fc_pkg::DREM_W-1:0] dsh;
        logic [fc_pkg::DREM_W-1:0] dsub;
        logic qbit;
        logic [fc_pkg::NUM_W-1:0] qfin;
        logic [3:0][W-1:0] prow;
        logic signed [fc_pkg::ACC_W-1:0] acc;

        state_next = state_reg;
        plane_next = plane_reg;
        kcnt_next = kcnt_reg;
        sq_next = sq_reg;
        sum_next = sum_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        cnt_next = cnt_reg;
        drem_next = drem_reg;
        num_next = num_reg;
        iss_next = iss_reg;
        rdv_next = 1'b0;
        rdl_next = 1'b0;
        mulv_next = rdv_reg;
        mull_next = rdl_reg;
        prod_next = prod_reg;
        p3_next = p3_reg;
        vis_next = vis_reg;
        cmd_pop = 1'b0;
        mtx_we = 1'b0;
        pln_we = 1'b0;
        pln_re = 1'b0;
        raw_we = 1'b0;
        comp_we = 1'b0;
        ld_sphere = 1'b0;
        out_valid_next = out_valid_reg && !rslt.ready;
        out_tag_next = out_tag_reg;
        out_vis_next = out_vis_reg;

        wa = mtx_vrd_reg[3] ? mtx_rd_reg[3] : '0;
        wb = mtx_vrd_reg[plane_reg[2:1]] ? mtx_rd_reg[plane_reg[2:1]] : '0;
        raw_new = plane_reg[0] ? ($signed({wa[W-1], wa}) - $signed({wb[W-1], wb}))
                               : ($signed({wa[W-1], wa}) + $signed({wb[W-1], wb}));
        rmag = raw_reg[kcnt_reg][fc_pkg::RAW_W-1] ? (~raw_reg[kcnt_reg] + 1'b1)
                                                  : raw_reg[kcnt_reg];
        srem = {rem_reg[fc_pkg::SREM_W-3:0], sum_reg[fc_pkg::SUM_W-1 -: 2]};
        strial = {1'b0, root_reg, 2'b01};
        dsh = {drem_reg, num_reg[fc_pkg::NUM_W-1]};
        dsub = dsh - {1'b0, root_reg};
        qbit = (dsh >= {1'b0, root_reg});
        qfin = {num_reg[fc_pkg::NUM_W-2:0], qbit};
        comp_new = fc_pkg::sat_word(raw_reg[kcnt_reg][fc_pkg::RAW_W-1], qfin);
        prow = pln_vrd_reg ? pln_rd_reg : '0;
        acc = $signed({1'b0, rad_reg, {fc_pkg::FRAC_W{1'b0}}})
            + prod_reg[0] + prod_reg[1] + prod_reg[2]
            + $signed({p3_reg, {fc_pkg::FRAC_W{1'b0}}});

        unique case (state_reg)
            fc_pkg::B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    priority case (cmd.op)
                        fc_pkg::OP_LOAD:
                        begin
                            mtx_we = 1'b1;
                        end
                        fc_pkg::OP_EXTRACT:
                        begin
                            plane_next = '0;
                            kcnt_next = '0;
                            state_next = fc_pkg::B_RD_ADDR;
                        end
                        fc_pkg::OP_TEST:
                        begin
                            ld_sphere = 1'b1;
                            iss_next = '0;
                            vis_next = 1'b1;
                            state_next = fc_pkg::B_TEST;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            fc_pkg::B_RD_ADDR:
            begin
                state_next = fc_pkg::B_RD_DATA;
            end
            fc_pkg::B_RD_DATA:
            begin
                raw_we = 1'b1;
                kcnt_next = kcnt_reg + 1'b1;
                if (kcnt_reg == 2'd3)
                begin
                    sum_next = '0;
                    state_next = fc_pkg::B_SQ_MUL;
                end
                else
                begin
                    state_next = fc_pkg::B_RD_ADDR;
                end
            end
            fc_pkg::B_SQ_MUL:
            begin
                sq_next = fc_pkg::SQ_W'(rmag) * fc_pkg::SQ_W'(rmag);
                state_next = fc_pkg::B_SQ_ACC;
            end
            fc_pkg::B_SQ_ACC:
            begin
                sum_next = sum_reg + fc_pkg::SUM_W'(sq_reg);
                if (kcnt_reg == 2'd2)
                begin
                    kcnt_next = '0;
                    rem_next = '0;
                    root_next = '0;
                    cnt_next = fc_pkg::CNT_W'(fc_pkg::LEN_W - 1);
                    state_next = fc_pkg::B_SQRT;
                end
                else
                begin
                    kcnt_next = kcnt_reg + 1'b1;
                    state_next = fc_pkg::B_SQ_MUL;
                end
            end
            fc_pkg::B_SQRT:
            begin
                // one root bit per cycle, two radicand bits shifted in
                sum_next = sum_reg << 2;
                if (srem >= strial)
                begin
                    rem_next = srem - strial;
                    root_next = {root_reg[fc_pkg::LEN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = srem;
                    root_next = {root_reg[fc_pkg::LEN_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = fc_pkg::B_DIV_INIT;
                end
            end
            fc_pkg::B_DIV_INIT:
            begin
                if (root_reg == '0)
                begin
                    // degenerate normal: plane kept unscaled
                    comp_we = 1'b1;
                    comp_new = fc_pkg::sat_word(raw_reg[kcnt_reg][fc_pkg::RAW_W-1],
                                                fc_pkg::NUM_W'(rmag));
                    kcnt_next = kcnt_reg + 1'b1;
                    if (kcnt_reg == 2'd3)
                    begin
                        state_next = fc_pkg::B_WR;
                    end
                end
                else
                begin
                    num_next = {rmag, {fc_pkg::FRAC_W{1'b0}}};
                    drem_next = '0;
                    cnt_next = fc_pkg::CNT_W'(fc_pkg::NUM_W - 1);
                    state_next = fc_pkg::B_DIV;
                end
            end
            fc_pkg::B_DIV:
            begin
                // restoring divide, quotient bits shift into the numerator register
                drem_next = qbit ? dsub[fc_pkg::DREM_W-2:0] : dsh[fc_pkg::DREM_W-2:0];
                num_next = qfin;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    comp_we = 1'b1;
                    kcnt_next = kcnt_reg + 1'b1;
                    state_next = (kcnt_reg == 2'd3) ? fc_pkg::B_WR : fc_pkg::B_DIV_INIT;
                end
            end
            fc_pkg::B_WR:
            begin
                pln_we = 1'b1;
                kcnt_next = '0;
                if (plane_reg == fc_pkg::PLANE_W'(fc_pkg::NPLANES - 1))
                begin
                    state_next = fc_pkg::B_IDLE;
                end
                else
                begin
                    plane_next = plane_reg + 1'b1;
                    state_next = fc_pkg::B_RD_ADDR;
                end
            end
            fc_pkg::B_TEST:
            begin
                // read, multiply and sum overlap, one plane per cycle
                if (iss_reg < fc_pkg::PLANE_W'(fc_pkg::NPLANES))
                begin
                    pln_re = 1'b1;
                    rdv_next = 1'b1;
                    rdl_next = (iss_reg == fc_pkg::PLANE_W'(fc_pkg::NPLANES - 1));
                    iss_next = iss_reg + 1'b1;
                end
                if (rdv_reg)
                begin
                    prod_next[0] = $signed(prow[0]) * cx_reg;
                    prod_next[1] = $signed(prow[1]) * cy_reg;
                    prod_next[2] = $signed(prow[2]) * cz_reg;
                    p3_next = prow[3];
                end
                if (mulv_reg && acc[fc_pkg::ACC_W-1])
                begin
                    vis_next = 1'b0;
                end
                if (mull_reg)
                begin
                    state_next = fc_pkg::B_OUT;
                end
            end
            fc_pkg::B_OUT:
            begin
                if (!out_valid_reg || rslt.ready)
                begin
                    out_valid_next = 1'b1;
                    out_tag_next = tag_reg;
                    out_vis_next = vis_reg;
                    state_next = fc_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = fc_pkg::B_IDLE;
            end
        endcase

        rslt.valid = out_valid_reg;
        rslt.result_tag = out_tag_reg;
        rslt.visible = out_vis_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fc_pkg::B_IDLE;
            mtx_vld_reg <= '0;
            pln_vld_reg <= '0;
            rdv_reg <= 1'b0;
            rdl_reg <= 1'b0;
            mulv_reg <= 1'b0;
            mull_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rdv_reg <= rdv_next;
            rdl_reg <= rdl_next;
            mulv_reg <= mulv_next;
            mull_reg <= mull_next;
            out_valid_reg <= out_valid_next;
            if (mtx_we)
            begin
                mtx_vld_reg[cmd.idx] <= 1'b1;
            end
            if (pln_we)
            begin
                pln_vld_reg[plane_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mtx_we)
        begin
            mtx_mem[cmd.idx[3:2]][cmd.idx[1:0]] <= cmd.value;
        end
        mtx_rd_reg <= mtx_mem[kcnt_reg];
        mtx_vrd_reg <= mtx_vld_reg[kcnt_reg*4 +: 4];
        if (pln_we)
        begin
            pln_mem[plane_reg] <= {comp_reg[3], comp_reg[2], comp_reg[1], comp_reg[0]};
        end
        if (pln_re)
        begin
            pln_rd_reg <= pln_mem[iss_reg];
            pln_vrd_reg <= pln_vld_reg[iss_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        plane_reg <= plane_next;
        kcnt_reg <= kcnt_next;
        sq_reg <= sq_next;
        sum_reg <= sum_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
        cnt_reg <= cnt_next;
        drem_reg <= drem_next;
        num_reg <= num_next;
        iss_reg <= iss_next;
        prod_reg <= prod_next;
        p3_reg <= p3_next;
        vis_reg <= vis_next;
        out_tag_reg <= out_tag_next;
        out_vis_reg <= out_vis_next;
        if (raw_we)
        begin
            raw_reg[kcnt_reg] <= raw_new;
        end
        if (comp_we)
        begin
            comp_reg[kcnt_reg] <= comp_new;
        end
        if (ld_sphere)
        begin
            cx_reg <= cmd.cx;
            cy_reg <= cmd.cy;
            cz_reg <= cmd.cz;
            rad_reg <= cmd.radius;
            tag_reg <= cmd.tag;
        end
    end

endmodule

@@ verif/fc_tb_ifs.sv @@
`timescale 1ns / 1ps
// testbench-side note: channel interfaces come from sv/fc_ifs.sv
// this file holds the checker module's shared types; depends on fc_pkg
package fc_tb_pkg;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [fc_pkg::TAG_W-1:0] tag;
        logic                     visible;
    } cull_result_t;

endpackage

@@ verif/fc_checker.sv @@
`timescale 1ns / 1ps
// watches the command and result channels of the sphere culler, predicts each result
// and compares; depends on fc_pkg, fc_tb_pkg and the channel interfaces
module fc_checker (
    input  logic          clk,
    input  logic          rst_n,
    fc_cmd_if.sink        cmd,
    fc_rslt_if.sink       rslt,
    output int            errors,
    output int            pending
);

    logic signed [31:0] mat [16];
    logic signed [31:0] pln [24];
    fc_tb_pkg::cull_result_t cull_queue[$];

    function automatic logic [63:0] root_of(input logic [67:0] s);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 35; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({68'd0, c} * {68'd0, c} <= {68'd0, s})
                r = c;
        end
        return r;
    endfunction

    task automatic build_planes();
        logic signed [32:0] raw [4];
        logic [32:0] m;
        logic [67:0] s;
        logic [63:0] len;
        logic [95:0] q;
        logic [31:0] v;
        logic neg;
        int ax;
        for (int p = 0; p < 6; p++)
        begin
            ax = p >> 1;
            s = '0;
            for (int k = 0; k < 4; k++)
                raw[k] = (p & 1) ? 33'(mat[4*k+3]) - 33'(mat[4*k+ax])
                                 : 33'(mat[4*k+3]) + 33'(mat[4*k+ax]);
            for (int k = 0; k < 3; k++)
            begin
                m = raw[k][32] ? 33'(-raw[k]) : 33'(raw[k]);
                s += {35'd0, m} * {35'd0, m};
            end
            len = root_of(s);
            for (int k = 0; k < 4; k++)
            begin
                neg = raw[k][32];
                m = neg ? 33'(-raw[k]) : 33'(raw[k]);
                q = (len == 0) ? {63'd0, m}
                               : ({63'd0, m} << fc_pkg::FRAC_W) / {32'd0, len};
                if (neg)
                    v = (q > 96'h8000_0000) ? 32'h8000_0000 : q[31:0];
                else
                    v = (q > 96'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
                pln[4*p+k] = neg ? -v : v;
            end
        end
    endtask

    function automatic logic sphere_visible(input logic signed [31:0] cx,
                                            input logic signed [31:0] cy,
                                            input logic signed [31:0] cz,
                                            input logic [30:0] r);
        logic signed [71:0] acc;
        for (int p = 0; p < 6; p++)
        begin
            acc = $signed({41'd0, r}) <<< fc_pkg::FRAC_W;
            acc += 72'(pln[4*p]) * 72'(cx);
            acc += 72'(pln[4*p+1]) * 72'(cy);
            acc += 72'(pln[4*p+2]) * 72'(cz);
            acc += 72'(pln[4*p+3]) <<< fc_pkg::FRAC_W;
            if (acc < 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fc_tb_pkg::cull_result_t want;
        if (!rst_n)
        begin
            foreach (mat[i]) mat[i] = '0;
            foreach (pln[i]) pln[i] = '0;
            cull_queue.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (rslt.valid && rslt.ready)
            begin
                if (cull_queue.size() == 0)
                begin
                    $display("%0t: unexpected beat tag %h visible %b", $time,
                             rslt.result_tag, rslt.visible);
                    errors++;
                end
                else
                begin
                    want = cull_queue.pop_front();
                    if (want.tag !== rslt.result_tag)
                    begin
                        $display("%0t: tag expected %h actual %h", $time, want.tag,
                                 rslt.result_tag);
                        errors++;
                    end
                    if (want.visible !== rslt.visible)
                    begin
                        $display("%0t: visible expected %b actual %b (tag %h)", $time,
                                 want.visible, rslt.visible, want.tag);
                        errors++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                case (fc_pkg::fc_op_t'(cmd.opcode))
                    fc_pkg::OP_LOAD:    mat[cmd.elem_index] = cmd.elem_value;
                    fc_pkg::OP_EXTRACT: build_planes();
                    fc_pkg::OP_TEST:
                    begin
                        want.tag = cmd.sphere_tag;
                        want.visible = sphere_visible(cmd.center_x, cmd.center_y,
                                                      cmd.center_z, cmd.sphere_radius);
                        cull_queue.insert(cull_queue.size(), want);
                    end
                    default: ;
                endcase
            end
            pending = cull_queue.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// stimulus and verdict for the frustum sphere culler; predictions come from fc_checker
// depends on fc_pkg, the channel interfaces, fc_tb_pkg, fc_checker and the block
module testbench;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors;
    int   pending;
    int   cycles = 0;
    int   item_no = 0;

    fc_cmd_if  cmd ();
    fc_rslt_if rslt ();

    frustum_sphere_cull u_top (.clk(clk), .rst_n(rst_n), .cmd(cmd.sink), .rslt(rslt.source));
    fc_checker u_chk (.clk(clk), .rst_n(rst_n), .cmd(cmd.sink), .rslt(rslt.sink),
                      .errors(errors), .pending(pending));

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > fc_tb_pkg::CYCLE_LIMIT)
        begin
            $display("frustum_sphere_cull: mismatch");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls, plus one long hold-off midway through the stream
    initial
    begin
        int g;
        bit held;
        held = 1'b0;
        rslt.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && item_no >= 150)
            begin
                held = 1'b1;
                rslt.ready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            g = gap_len();
            if (g > 0)
            begin
                rslt.ready <= 1'b0;
                repeat (g - 1) @(negedge clk);
                @(negedge clk);
            end
            rslt.ready <= 1'b1;
        end
    end

    // valid stays up after a beat so back-to-back beats need no extra edge
    task automatic send(input fc_pkg::fc_op_t op, input logic [3:0] idx,
                        input logic [31:0] val,
                        input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                        input logic [30:0] r, input logic [15:0] tg, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.opcode <= op;
        cmd.elem_index <= idx;
        cmd.elem_value <= val;
        cmd.center_x <= x;
        cmd.center_y <= y;
        cmd.center_z <= z;
        cmd.sphere_radius <= r;
        cmd.sphere_tag <= tg;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load(input logic [3:0] idx, input logic [31:0] val);
        send(fc_pkg::OP_LOAD, idx, val, '0, '0, '0, '0, '0, 1'b1);
    endtask

    task automatic probe(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                         input logic [30:0] r, input bit gaps);
        send(fc_pkg::OP_TEST, 4'($urandom), $urandom, x, y, z, r, 16'($urandom), gaps);
    endtask

    function automatic logic [31:0] coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h000a_0000)) - 32'sh0005_0000);
            2: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
            default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
        endcase
    endfunction

    // a plausible projection matrix with random perturbation, or raw noise
    task automatic random_matrix();
        logic [31:0] v;
        for (int i = 0; i < 16; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                v = $urandom;
            else if (i == 0 || i == 5 || i == 10 || i == 11 || i == 14)
                v = 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
            else
                v = 32'($signed($urandom_range(0, 32'h0000_4000)) - 32'sh0000_2000);
            load(4'(i), v);
        end
    endtask

    initial
    begin
        int n;
        logic [30:0] rad;
        cmd.valid = 1'b0;
        cmd.opcode = '0;
        cmd.elem_index = '0;
        cmd.elem_value = '0;
        cmd.center_x = '0;
        cmd.center_y = '0;
        cmd.center_z = '0;
        cmd.sphere_radius = '0;
        cmd.sphere_tag = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // planes still zero before any extraction
        probe(32'h8000_0000, 32'h7fff_ffff, 32'h0, 31'h0, 1'b0);
        send(fc_pkg::OP_NONE, 4'hf, '1, '1, '1, '1, '1, 16'hffff, 1'b0);
        // all-zero matrix gives zero-length normals
        send(fc_pkg::OP_EXTRACT, '0, '0, '0, '0, '0, '0, '0, 1'b0);
        probe(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 31'h7fff_ffff, 1'b0);
        // identity matrix, then spheres inside, touching, outside
        for (int i = 0; i < 16; i++)
            load(4'(i), (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
        send(fc_pkg::OP_EXTRACT, '0, '0, '0, '0, '0, '0, '0, 1'b0);
        probe(32'h0, 32'h0, 32'h0, 31'h0, 1'b0);
        probe(32'h0002_0000, 32'h0, 32'h0, 31'h0001_0000, 1'b0);
        probe(32'h0002_0000, 32'h0, 32'h0, 31'h0000_ffff, 1'b0);
        probe(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff, 1'b0);
        // extreme elements push raw plane sums beyond the signed word range
        load(4'd3, 32'h7fff_ffff);
        load(4'd0, 32'h7fff_ffff);
        load(4'd15, 32'h8000_0000);
        load(4'd7, 32'h8000_0000);
        send(fc_pkg::OP_EXTRACT, '0, '0, '0, '0, '0, '0, '0, 1'b0);
        probe(32'hffff_ffff, 32'h0000_0001, 32'h8000_0000, 31'h1, 1'b0);

        for (int i = 0; i < 300; i++)
        begin
            item_no = i;
            n = $urandom_range(0, 99);
            if (i % 60 == 0)
            begin
                random_matrix();
                send(fc_pkg::OP_EXTRACT, 4'($urandom), $urandom, '0, '0, '0, '0, '0, 1'b1);
            end
            else if (n < 4)
                load(4'($urandom), $urandom);
            else if (n < 6)
                send(fc_pkg::OP_NONE, 4'($urandom), $urandom, $urandom, $urandom, $urandom,
                     31'($urandom), 16'($urandom), 1'b1);
            else
            begin
                rad = ($urandom_range(0, 1) == 1) ? 31'($urandom)
                                                  : 31'($urandom_range(0, 32'h0008_0000));
                probe(coord(), coord(), coord(), rad, (i < 100 || i > 200));
            end
            if (i == 250)
            begin
                cmd.valid <= 1'b0;
                @(negedge clk);
                while (pending != 0) @(negedge clk);
            end
        end

        cmd.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("frustum_sphere_cull: match");
        else
            $display("frustum_sphere_cull: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
sv/fc_pkg.sv
sv/fc_ifs.sv
sv/fc_front.sv
sv/fc_queue.sv
sv/fc_back.sv
sv/frustum_sphere_cull.sv
verif/fc_tb_ifs.sv
verif/fc_checker.sv
verif/testbench.sv
